[rtl/core/rrqs_pkg.sv]
// rrqs_pkg: shared constants, command codes and pointer helpers for the
// round-robin ready-queue scheduler; no dependencies
`timescale 1ns / 1ps

package rrqs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 8;
    localparam int KIND_W      = 2;
    localparam int COUNT_OUT_W = 5;
    localparam int OUT_DATA_W  = 16;

    localparam logic [KIND_W-1:0] KIND_ADD      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SCHEDULE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH   = 2'd2;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        ptr_inc = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

endpackage

[rtl/core/rrqs_ram.sv]
// rrqs_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module rrqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/round_robin_ready_queue_scheduler_top.sv]
// round_robin_ready_queue_scheduler_top: command decode, queue pointers and result register
// depends on rrqs_pkg and rrqs_ram
`timescale 1ns / 1ps

// Round-robin thread scheduler. Each input transaction carries one command in
// s_tuser (add, schedule, finish; code 3 is a no-op) and a thread id in s_tdata;
// each yields exactly one result transaction with the running thread, the idle
// flag, the ready queue fill and a drop flag for an add to a full queue. Waiting
// ids live in a ram with a registered read. Commands are handled one at a
// time: an add, a no-op or a command that pops nothing goes from acceptance
// straight to the output state, which loads its result into the result
// register; a schedule or finish that pops the queue head first passes through
// a read state for the ram read and then loads its result in the output state.
// A new command is accepted as soon as the previous one has reached the result
// register, even while that result waits; the new command then holds before
// the result register until the waiting result has been taken.

module round_robin_ready_queue_scheduler_top
    import rrqs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [ID_W-1:0]       s_tdata,   // [7:0] thread_id
    input  logic [KIND_W-1:0]     s_tuser,   // [1:0] kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] running_id, [12:8] queue_count
    output logic [1:0]            m_tuser    // [0] running_idle, [1] dropped
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_OUT
    } state_t;

    state_t                  state_reg;
    logic [PTR_W-1:0]        head_reg;
    logic [PTR_W-1:0]        tail_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [ID_W-1:0]         running_reg;
    logic                    idle_reg;
    logic [KIND_W-1:0]       kind_reg;
    logic                    drop_reg;
    logic                    m_tvalid_reg;
    logic [OUT_DATA_W-1:0]   m_tdata_reg;
    logic [1:0]              m_tuser_reg;

    logic                    accept;
    logic                    full;
    logic                    wr_en;
    logic [ID_W-1:0]         wr_data;
    logic [ID_W-1:0]         rd_data;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        wr_en   = 1'b0;
        wr_data = s_tdata;
        if (accept && s_tuser == KIND_ADD && !full) begin
            wr_en = 1'b1;
        end else if (state_reg == ST_READ && kind_reg == KIND_SCHEDULE && !idle_reg) begin
            wr_en   = 1'b1;
            wr_data = running_reg;
        end
    end

    rrqs_ram #(
        .WIDTH (ID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            running_reg  <= '0;
            idle_reg     <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        kind_reg  <= s_tuser;
                        drop_reg  <= (s_tuser == KIND_ADD) && full;
                        state_reg <= ((s_tuser == KIND_SCHEDULE || s_tuser == KIND_FINISH)
                                      && count_reg != '0) ? ST_READ : ST_OUT;
                        case (s_tuser)
                            KIND_ADD: begin
                                if (!full) begin
                                    tail_reg  <= ptr_inc(tail_reg);
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            KIND_FINISH: begin
                                if (count_reg == '0) begin
                                    running_reg <= '0;
                                    idle_reg    <= 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    // head entry arrives from the ram; requeue the old thread on schedule
                    running_reg <= rd_data;
                    idle_reg    <= 1'b0;
                    head_reg    <= ptr_inc(head_reg);
                    if (kind_reg == KIND_SCHEDULE && !idle_reg) begin
                        tail_reg <= ptr_inc(tail_reg);
                    end else begin
                        count_reg <= count_reg - 1'b1;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {3'b000, COUNT_OUT_W'(count_reg),
                                         idle_reg ? {ID_W{1'b0}} : running_reg};
                        m_tuser_reg  <= {drop_reg, idle_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
